/* rtl/sbg_pkg.sv */
`timescale 1ns / 1ps
package sbg_pkg;

  // Expansion constants
  localparam logic [31:0] EXP_C0 = 32'h6170_7865;
  localparam logic [31:0] EXP_C3 = 32'h6b20_6574;
  localparam logic [31:0] SIG_C1 = 32'h3320_646e;
  localparam logic [31:0] SIG_C2 = 32'h7962_2d32;
  localparam logic [31:0] TAU_C1 = 32'h3120_646e;
  localparam logic [31:0] TAU_C2 = 32'h7962_2d36;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_KEY0     = 3'd0;
  localparam logic [2:0] REG_KEY1     = 3'd1;
  localparam logic [2:0] REG_KEY2     = 3'd2;
  localparam logic [2:0] REG_KEY3     = 3'd3;
  localparam logic [2:0] REG_LONG_KEY = 3'd4;

  // Last phase of a double round: the cells hand over on it
  localparam logic [2:0] PH_LAST  = 3'd7;
  // Index of the final 64-bit slice of a block
  localparam logic [2:0] IDX_LAST = 3'd7;

  // Rotation of each quarter-round step
  localparam logic [1:0] STEP_A = 2'd0;
  localparam logic [1:0] STEP_B = 2'd1;
  localparam logic [1:0] STEP_C = 2'd2;
  localparam logic [1:0] STEP_D = 2'd3;

  // Word positions (a, b, c, d) of each quarter round: column round, then row round
  localparam logic [3:0] QR_IDX [2][4][4] = '{
    '{'{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2,  4'd6},
      '{4'd15, 4'd3,  4'd7,  4'd11}},
    '{'{4'd0,  4'd1,  4'd2,  4'd3},
      '{4'd5,  4'd6,  4'd7,  4'd4},
      '{4'd10, 4'd11, 4'd8,  4'd9},
      '{4'd15, 4'd12, 4'd13, 4'd14}}
  };

  typedef logic [15:0][31:0] sbg_state_t;

  typedef struct packed {
    logic [63:0] k0;
    logic [63:0] k1;
    logic [63:0] k2;
    logic [63:0] k3;
    logic        long_key;
  } sbg_key_t;

  // One block in flight between cells
  typedef struct packed {
    logic        vld;
    sbg_state_t  w;
    logic [63:0] n_lo;
    logic [63:0] n_hi;
  } sbg_blk_t;

  // Chain control shared by all cells
  typedef struct packed {
    logic       run;
    logic [2:0] ph;
  } sbg_ctl_t;

  function automatic logic [31:0] rotl_step(input logic [31:0] v, input logic [1:0] k);
    logic [31:0] r;
    case (k)
      STEP_A:  r = {v[24:0], v[31:25]};
      STEP_B:  r = {v[22:0], v[31:23]};
      STEP_C:  r = {v[18:0], v[31:19]};
      default: r = {v[13:0], v[31:14]};
    endcase
    return r;
  endfunction

  // Assemble the input matrix from key, mode and nonce block
  function automatic sbg_state_t build_init(input sbg_key_t key, input logic [63:0] n_lo,
                                            input logic [63:0] n_hi);
    sbg_state_t  w;
    logic [63:0] kb0;
    logic [63:0] kb1;
    kb0   = key.long_key ? key.k2 : key.k0;
    kb1   = key.long_key ? key.k3 : key.k1;
    w[0]  = EXP_C0;
    w[1]  = key.k0[31:0];
    w[2]  = key.k0[63:32];
    w[3]  = key.k1[31:0];
    w[4]  = key.k1[63:32];
    w[5]  = key.long_key ? SIG_C1 : TAU_C1;
    w[6]  = n_lo[31:0];
    w[7]  = n_lo[63:32];
    w[8]  = n_hi[31:0];
    w[9]  = n_hi[63:32];
    w[10] = key.long_key ? SIG_C2 : TAU_C2;
    w[11] = kb0[31:0];
    w[12] = kb0[63:32];
    w[13] = kb1[31:0];
    w[14] = kb1[63:32];
    w[15] = EXP_C3;
    return w;
  endfunction

  // One step of the four parallel quarter rounds; ph[2] picks column or row round
  function automatic sbg_state_t salsa_step(input sbg_state_t s, input logic [2:0] ph);
    sbg_state_t  r;
    logic [1:0]  k;
    logic [1:0]  kd;
    logic [1:0]  ky;
    logic [3:0]  dst;
    logic [3:0]  xi;
    logic [3:0]  yi;
    logic [31:0] sum;
    r  = s;
    k  = ph[1:0];
    kd = k + 2'd1;
    ky = k - 2'd1;
    for (int q = 0; q < 4; q++) begin
      dst    = QR_IDX[ph[2]][2'(q)][kd];
      xi     = QR_IDX[ph[2]][2'(q)][k];
      yi     = QR_IDX[ph[2]][2'(q)][ky];
      sum    = s[xi] + s[yi];
      r[dst] = s[dst] ^ rotl_step(sum, k);
    end
    return r;
  endfunction

endpackage

/* rtl/sbg_cell.sv */
`timescale 1ns / 1ps
// One double round: a quarter-round step on every cycle while the chain runs, handover on the last phase
module sbg_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  sbg_pkg::sbg_ctl_t ctl,
  input  sbg_pkg::sbg_blk_t blk_i,
  output sbg_pkg::sbg_blk_t blk_o
);

  logic                vld_r;
  sbg_pkg::sbg_state_t w_r;
  logic [63:0]         n_lo_r;
  logic [63:0]         n_hi_r;
  sbg_pkg::sbg_state_t stp;
  logic                hand;

  assign hand = (ctl.ph == sbg_pkg::PH_LAST);
  assign stp  = sbg_pkg::salsa_step(w_r, ctl.ph);

  // Hold the valid flag of the block in this cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.run && hand) begin
      vld_r <= blk_i.vld;
    end
  end

  // Advance the state, or take the upstream block on handover
  always_ff @(posedge clk) begin
    if (ctl.run) begin
      if (hand) begin
        w_r    <= blk_i.w;
        n_lo_r <= blk_i.n_lo;
        n_hi_r <= blk_i.n_hi;
      end else begin
        w_r <= stp;
      end
    end
  end

  // Downstream sees this cycle's stepped state
  assign blk_o.vld  = vld_r;
  assign blk_o.w    = stp;
  assign blk_o.n_lo = n_lo_r;
  assign blk_o.n_hi = n_hi_r;

endmodule

/* rtl/sbg_out.sv */
`timescale 1ns / 1ps
// Output buffer: feed-forward add and emission of eight 64-bit slices
module sbg_out (
  input  logic              clk,
  input  logic              rst_n,
  input  sbg_pkg::sbg_ctl_t ctl,
  input  sbg_pkg::sbg_blk_t blk_i,
  input  sbg_pkg::sbg_key_t key,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_stream_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);

  logic                vld_r;
  logic [2:0]          idx_r;
  sbg_pkg::sbg_state_t w_r;
  logic [63:0]         n_lo_r;
  logic [63:0]         n_hi_r;
  sbg_pkg::sbg_state_t ff;
  logic                fire;
  logic                load;
  logic [3:0]          wi_lo;
  logic [3:0]          wi_hi;
  logic [31:0]         word_lo;
  logic [31:0]         word_hi;

  assign fire = vld_r && out_ready;
  assign free = !vld_r || (fire && (idx_r == sbg_pkg::IDX_LAST));
  assign load = ctl.run && (ctl.ph == sbg_pkg::PH_LAST) && blk_i.vld;

  // Track the slice being offered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 3'd0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= 3'd0;
    end else if (fire) begin
      if (idx_r == sbg_pkg::IDX_LAST) begin
        vld_r <= 1'b0;
      end
      idx_r <= idx_r + 3'd1;
    end
  end

  // Capture the finished rounds of a block
  always_ff @(posedge clk) begin
    if (load) begin
      w_r    <= blk_i.w;
      n_lo_r <= blk_i.n_lo;
      n_hi_r <= blk_i.n_hi;
    end
  end

  // Add the input matrix back in for the two words of this slice
  assign ff      = sbg_pkg::build_init(key, n_lo_r, n_hi_r);
  assign wi_lo   = {idx_r, 1'b0};
  assign wi_hi   = {idx_r, 1'b1};
  assign word_lo = w_r[wi_lo] + ff[wi_lo];
  assign word_hi = w_r[wi_hi] + ff[wi_hi];

  assign out_valid       = vld_r;
  assign out_stream_word = {word_hi, word_lo};
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == sbg_pkg::IDX_LAST);

endmodule

/* rtl/salsa20_block_generator.sv */
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_nonce_low, in_nonce_high
// out     | output    | out_valid/out_ready| out_stream_word, out_word_index, out_last_word
// cfg     | APB slave | psel/penable/pready| paddr, pwdata, prdata (64-bit, 8*i)
//
// New items enter while earlier ones are in flight: each cell of the chain runs one
// double round, one quarter-round step per cycle while the chain runs, and hands its
// block on at the last phase.
// Synchronous active-low reset clears valid flags and restores the key registers.
// A stalled output freezes the whole chain at its handover phase; input holds one item.
module salsa20_block_generator #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_nonce_low,
  input  logic [63:0] in_nonce_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_stream_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  sbg_pkg::sbg_key_t key_r;
  logic              wr;
  logic [2:0]        reg_idx;
  logic [2:0]        ph_r;
  logic              run;
  logic              hand_go;
  logic              hold_vld_r;
  logic [63:0]       hold_lo_r;
  logic [63:0]       hold_hi_r;
  logic              ob_free;
  sbg_pkg::sbg_ctl_t ctl;
  sbg_pkg::sbg_blk_t chain [DOUBLE_ROUNDS+1];

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r.k0       <= 64'd0;
      key_r.k1       <= 64'd0;
      key_r.k2       <= 64'd0;
      key_r.k3       <= 64'd0;
      key_r.long_key <= 1'b1;
    end else if (wr) begin
      unique case (reg_idx)
        sbg_pkg::REG_KEY0:     key_r.k0       <= pwdata;
        sbg_pkg::REG_KEY1:     key_r.k1       <= pwdata;
        sbg_pkg::REG_KEY2:     key_r.k2       <= pwdata;
        sbg_pkg::REG_KEY3:     key_r.k3       <= pwdata;
        sbg_pkg::REG_LONG_KEY: key_r.long_key <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sbg_pkg::REG_KEY0:     prdata = key_r.k0;
      sbg_pkg::REG_KEY1:     prdata = key_r.k1;
      sbg_pkg::REG_KEY2:     prdata = key_r.k2;
      sbg_pkg::REG_KEY3:     prdata = key_r.k3;
      sbg_pkg::REG_LONG_KEY: prdata = {63'd0, key_r.long_key};
      default:               prdata = 64'd0;
    endcase
  end

  // Stall the chain only when a finished block cannot enter the output buffer
  assign run     = !((ph_r == sbg_pkg::PH_LAST) && chain[DOUBLE_ROUNDS].vld && !ob_free);
  assign hand_go = run && (ph_r == sbg_pkg::PH_LAST);
  assign ctl.run = run;
  assign ctl.ph  = ph_r;

  // Advance the step phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 3'd0;
    end else if (run) begin
      ph_r <= ph_r + 3'd1;
    end
  end

  // Hold one input item until the first cell takes it
  assign in_ready = !hold_vld_r || hand_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_vld_r <= 1'b1;
    end else if (hand_go) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_lo_r <= in_nonce_low;
      hold_hi_r <= in_nonce_high;
    end
  end

  assign chain[0].vld  = hold_vld_r;
  assign chain[0].w    = sbg_pkg::build_init(key_r, hold_lo_r, hold_hi_r);
  assign chain[0].n_lo = hold_lo_r;
  assign chain[0].n_hi = hold_hi_r;

  // Row of double-round cells
  for (genvar i = 0; i < DOUBLE_ROUNDS; i++) begin : g_cell
    sbg_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .blk_i (chain[i]),
      .blk_o (chain[i+1])
    );
  end

  sbg_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .blk_i           (chain[DOUBLE_ROUNDS]),
    .key             (key_r),
    .free            (ob_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_stream_word (out_stream_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule
